// ===== sv/dsi_pkg.sv =====
package dsi_pkg;

  localparam int unsigned DEC_BASE = 10;
  localparam int unsigned ACC_W    = 64;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // accumulator bound: INT64_MIN / 10, and the largest digit allowed at it
  localparam logic signed [ACC_W-1:0] ACC_LIM   = -64'sd922337203685477580;
  localparam logic [3:0]              DIGIT_LIM = 4'd8;
  localparam logic signed [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam logic [1:0] WM_8  = 2'd0;
  localparam logic [1:0] WM_16 = 2'd1;
  localparam logic [1:0] WM_32 = 2'd2;
  localparam logic [1:0] WM_64 = 2'd3;

  typedef enum logic [1:0] {
    P_START  = 2'd0,
    P_SIGN   = 2'd1,
    P_DIGITS = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    TOK_NONE  = 2'd0,
    TOK_DIGIT = 2'd1,
    TOK_FAULT = 2'd2
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               status;
  } out_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic       last;
    logic       neg;
    logic       digits_ok;
  } tok_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic                    neg;
    logic                    bad;
  } fin_t;

endpackage

// ===== sv/dsi_front.sv =====
module dsi_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  dsi_pkg::in_t  in_data,
  output logic          push,
  output dsi_pkg::tok_t push_tok,
  input  logic          q_full
);
  import dsi_pkg::*;

  phase_t phase, phase_next;
  logic   neg, neg_next;
  logic   take;
  logic   is_digit, is_sign;
  logic [7:0] diff;

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;
  assign diff     = in_data.char_code - CH_ZERO;

  always_comb begin
    is_digit   = in_data.char_code inside {[CH_ZERO:CH_NINE]};
    is_sign    = (in_data.char_code == CH_PLUS) || (in_data.char_code == CH_MINUS);
    phase_next = phase;
    neg_next   = neg;
    push_tok.kind = TOK_NONE;
    if (in_data.has_char) begin
      if (phase == P_START && is_sign) begin
        neg_next   = (in_data.char_code == CH_MINUS);
        phase_next = P_SIGN;
      end else if (!is_digit) begin
        push_tok.kind = TOK_FAULT;
      end else begin
        push_tok.kind = TOK_DIGIT;
        phase_next    = P_DIGITS;
      end
    end
    push_tok.digit     = diff[3:0];
    push_tok.last      = in_data.is_last;
    push_tok.neg       = neg_next;
    push_tok.digits_ok = (phase_next == P_DIGITS);
  end

  // a beat with no byte that does not end the string leaves no trace
  assign push = take && (in_data.has_char || in_data.is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_START;
      neg   <= 1'b0;
    end else if (take) begin
      if (in_data.is_last) begin
        phase <= P_START;
        neg   <= 1'b0;
      end else begin
        phase <= phase_next;
        neg   <= neg_next;
      end
    end
  end

endmodule

// ===== sv/dsi_queue.sv =====
module dsi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dsi_pkg::tok_t push_tok,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output dsi_pkg::tok_t head_tok
);
  import dsi_pkg::*;

  tok_t          mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   count;

  assign full       = (count == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/dsi_back.sv =====
module dsi_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  dsi_pkg::tok_t head_tok,
  output logic          pop,
  output logic          fin_valid,
  output dsi_pkg::fin_t fin_data,
  input  logic          fin_take
);
  import dsi_pkg::*;

  logic signed [ACC_W-1:0] acc, acc_next, acc_x10;
  logic                    failed, failed_next;
  logic                    ovf, fin_ready;

  assign fin_ready = !fin_valid || fin_take;
  assign pop       = head_valid && (!head_tok.last || fin_ready);

  // acc * 10 - d, acc kept non-positive so INT64_MIN fits
  assign acc_x10 = (acc <<< 3) + (acc <<< 1);
  assign ovf     = (acc < ACC_LIM) || ((acc == ACC_LIM) && (head_tok.digit > DIGIT_LIM));

  always_comb begin
    acc_next    = acc;
    failed_next = failed;
    case (head_tok.kind)
      TOK_DIGIT: begin
        if (!failed) begin
          if (ovf) begin
            failed_next = 1'b1;
          end else begin
            acc_next = acc_x10 - $signed({{(ACC_W-4){1'b0}}, head_tok.digit});
          end
        end
      end
      TOK_FAULT: failed_next = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      failed    <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      if (pop && head_tok.last) begin
        fin_valid <= 1'b1;
      end else if (fin_take) begin
        fin_valid <= 1'b0;
      end
      if (pop) begin
        if (head_tok.last) begin
          acc    <= '0;
          failed <= 1'b0;
        end else begin
          acc    <= acc_next;
          failed <= failed_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_tok.last) begin
      fin_data.acc <= acc_next;
      fin_data.neg <= head_tok.neg;
      fin_data.bad <= failed_next || !head_tok.digits_ok;
    end
  end

endmodule

// ===== sv/dsi_finish.sv =====
module dsi_finish (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    width_mode,
  input  logic          fin_valid,
  input  dsi_pkg::fin_t fin_data,
  output logic          fin_take,
  output logic          out_valid,
  input  logic          out_stall,
  output dsi_pkg::out_t out_data
);
  import dsi_pkg::*;

  logic signed [63:0] v;
  logic               bad, in_range;

  assign fin_take = fin_valid && (!out_valid || !out_stall);

  always_comb begin
    v   = fin_data.neg ? fin_data.acc : -fin_data.acc;
    bad = fin_data.bad || (!fin_data.neg && fin_data.acc == ACC_MIN);
    case (width_mode)
      WM_8:    in_range = ({{56{v[7]}},  v[7:0]}  == v);
      WM_16:   in_range = ({{48{v[15]}}, v[15:0]} == v);
      WM_32:   in_range = ({{32{v[31]}}, v[31:0]} == v);
      default: in_range = 1'b1;
    endcase
    bad = bad || !in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_data.value  <= bad ? 64'sd0 : v;
      out_data.status <= bad;
    end
  end

endmodule

// ===== sv/decimal_string_to_signed_int.sv =====
// channel   dir  handshake          payload
// in        in   in_valid/in_stall  in_data    (char_code, has_char, is_last)
// out       out  out_valid/out_stall out_data  (value, status)
// cfg       in   cfg_valid/cfg_ready cfg_data  (width_mode)
//
// One byte per cycle while the token queue has room; the back end's
// multiply-by-ten step handles one queued token per cycle, but an ending
// token waits while a result is held. It passes queue, back end and
// output registers. Synchronous reset clears phase, accumulator, queue
// and output valid; width_mode resets to 64 bits. A 4-deep token queue
// lets the front keep taking bytes while the output is stalled.
module decimal_string_to_signed_int (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  dsi_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dsi_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_data
);
  import dsi_pkg::*;

  logic [1:0] width_mode;
  logic       push, q_full, pop, head_valid;
  tok_t       push_tok, head_tok;
  logic       fin_valid, fin_take;
  fin_t       fin_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode <= WM_64;
    end else if (cfg_valid && cfg_ready) begin
      width_mode <= cfg_data;
    end
  end

  dsi_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .push, .push_tok, .q_full
  );

  dsi_queue u_queue (
    .clk, .rst, .push, .push_tok, .full(q_full),
    .pop, .head_valid, .head_tok
  );

  dsi_back u_back (
    .clk, .rst, .head_valid, .head_tok, .pop,
    .fin_valid, .fin_data, .fin_take
  );

  dsi_finish u_finish (
    .clk, .rst, .width_mode, .fin_valid, .fin_data, .fin_take,
    .out_valid, .out_stall, .out_data
  );

endmodule

// ===== sv/dsi_checker.sv =====
module dsi_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input dsi_pkg::out_t out_data
);
  import dsi_pkg::*;

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.value == 64'sd0)
    else $error("failed result carries nonzero value");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // when a result rises, reset was low at both $past samples
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(rst, 1) && !$past(rst, 2))
    else $error("result appeared too soon after reset");

endmodule

bind decimal_string_to_signed_int dsi_checker u_dsi_checker (.*);

// ===== dv/tb_decimal_string_to_signed_int.sv =====
`timescale 1ns / 1ps

module tb_decimal_string_to_signed_int;
  import dsi_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_TARGET = 1800;

  // INT64_MIN / 10, truncated toward zero
  localparam logic signed [63:0] ACC_FLOOR = -64'sd922337203685477580;
  localparam logic signed [63:0] I64_MIN   = 64'sh8000000000000000;
  localparam logic signed [63:0] I64_MAX   = 64'sh7fffffffffffffff;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  [1:0] cfg_data;

  decimal_string_to_signed_int dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // converter mirror
  logic [1:0]         m_width;
  phase_t             m_phase;
  bit                 m_neg;
  logic signed [63:0] m_acc;
  bit                 m_fail;

  out_t parsed_q[$];
  int   mismatches;
  int   sent_items;
  int   idle_cycles;
  int   stall_left;
  bit   in_calm;
  bit   out_calm;
  logic [7:0] str_bytes[$];

  typedef struct {
    logic [1:0] mode;
    string      text;
    int         skip_at;
    bit         typed;
    out_t       want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void clear_parse();
    m_phase = P_START;
    m_neg   = 1'b0;
    m_acc   = '0;
    m_fail  = 1'b0;
  endfunction

  function automatic bit parse_item(input in_t it, output out_t res);
    logic [7:0]         c;
    logic signed [63:0] d;
    logic signed [63:0] v;
    bit                 bad;
    c   = it.char_code;
    res = '0;
    v   = '0;
    if (it.has_char) begin
      if (m_phase == P_START && (c == CH_MINUS || c == CH_PLUS)) begin
        m_neg   = (c == CH_MINUS);
        m_phase = P_SIGN;
      end else if (c < CH_ZERO || c > CH_NINE) begin
        m_fail = 1'b1;
      end else begin
        d = $signed({56'd0, 8'(c - CH_ZERO)});
        if (!m_fail) begin
          if (m_acc < ACC_FLOOR || (m_acc == ACC_FLOOR && d > 64'sd8))
            m_fail = 1'b1;
          else
            m_acc = m_acc * 64'sd10 - d;
        end
        m_phase = P_DIGITS;
      end
    end
    if (!it.is_last)
      return 1'b0;
    bad = m_fail || m_phase != P_DIGITS;
    if (!bad) begin
      if (m_neg)
        v = m_acc;
      else if (m_acc == I64_MIN)
        bad = 1'b1;
      else
        v = -m_acc;
    end
    if (!bad) begin
      case (m_width)
        WM_8:    bad = v < -64'sd128 || v > 64'sd127;
        WM_16:   bad = v < -64'sd32768 || v > 64'sd32767;
        WM_32:   bad = v < -64'sd2147483648 || v > 64'sd2147483647;
        default: bad = 1'b0;
      endcase
    end
    res.value  = bad ? 64'sd0 : v;
    res.status = bad;
    clear_parse();
    return 1'b1;
  endfunction

  // wait length per beat; calm stretches give back-to-back traffic
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 29) == 0)
      calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_item(input logic [7:0] c, input bit has, input bit last,
                           input bit typed, input out_t want);
    int   gap;
    in_t  it;
    out_t res;
    gap = draw_wait(in_calm);
    it  = '{char_code: c, has_char: has, is_last: last};
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (parse_item(it, res))
      parsed_q.push_back(typed ? want : res);
    if (has || last)
      sent_items++;
  endtask

  task automatic send_string(input logic [7:0] chars[$], input int skip_at,
                             input bit sprinkle, input bit tail_empty,
                             input bit typed, input out_t want);
    int n;
    n = chars.size();
    if (n == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, typed, want);
      return;
    end
    for (int i = 0; i < n; i++) begin
      // beat with no byte and not last: must be ignored
      if (i == skip_at || (sprinkle && $urandom_range(0, 15) == 0))
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, typed, want);
      send_item(chars[i], 1'b1, (i == n - 1) && !tail_empty, typed, want);
    end
    if (tail_empty)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, typed, want);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_width(input logic [1:0] mode);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_width = mode;
  endtask

  function automatic void add_row(input logic [1:0] mode, input string text,
                                  input int skip_at, input bit typed,
                                  input longint val, input bit st);
    dir_row_t r;
    r.mode        = mode;
    r.text        = text;
    r.skip_at     = skip_at;
    r.typed       = typed;
    r.want.value  = val;
    r.want.status = st;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0, 1:    return CH_ZERO + 8'($urandom_range(0, 9));
      2:       return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void make_string();
    int     pick;
    int     bits;
    int     n;
    int     start;
    longint v;
    longint lo;
    longint hi;
    string  s;
    str_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // well formed, often at or just past the edges of the selected width
      bits = 8 << m_width;
      hi   = (bits == 64) ? I64_MAX : (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo   = -hi - 1;
      case ($urandom_range(0, 3))
        0:       v = hi - longint'($urandom_range(0, 2));
        1:       v = lo + longint'($urandom_range(0, 2));
        2:       v = $signed({$urandom, $urandom}) >>> (64 - bits);
        default: v = longint'($urandom_range(0, 2000)) - 1000;
      endcase
      if (bits < 64 && $urandom_range(0, 4) == 0)
        v = (v < 0) ? lo - 1 - longint'($urandom_range(0, 2))
                    : hi + 1 + longint'($urandom_range(0, 2));
      s     = $sformatf("%0d", v);
      start = (s[0] == CH_MINUS) ? 1 : 0;
      if (start == 1)
        str_bytes.push_back(CH_MINUS);
      else if ($urandom_range(0, 2) == 0)
        str_bytes.push_back(CH_PLUS);
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) str_bytes.push_back(CH_ZERO);
      for (int i = start; i < s.len(); i++)
        str_bytes.push_back(s[i]);
    end else if (pick < 85) begin
      // digit runs: long ones around the 64-bit bound, short ones with one noise byte
      case ($urandom_range(0, 2))
        0: str_bytes.push_back(CH_PLUS);
        1: str_bytes.push_back(CH_MINUS);
        default: ;
      endcase
      n = (pick < 70) ? $urandom_range(15, 22) : $urandom_range(1, 8);
      repeat (n) str_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if (pick >= 70)
        str_bytes[$urandom_range(0, str_bytes.size() - 1)] = noise_byte();
    end else begin
      repeat ($urandom_range(0, 6)) str_bytes.push_back(noise_byte());
    end
  endfunction

  // result side: random stall per beat, compare against the oldest prediction
  always @(posedge clk) begin : rx
    out_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parsed_q.size() == 0) begin
          flag_mismatch($sformatf("result with none pending: value=%0d status=%0b",
                                  out_data.value, out_data.status));
        end else begin
          want = parsed_q.pop_front();
          if (out_data.value !== want.value)
            flag_mismatch($sformatf("value %0d, want %0d",
                                    out_data.value, want.value));
          if (out_data.status !== want.status)
            flag_mismatch($sformatf("status %0b, want %0b",
                                    out_data.status, want.status));
        end
        stall_left = draw_wait(out_calm);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stim
    logic [7:0] bytes[$];
    int         n_str;
    bit         tail;
    bit         first;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = 2'd0;
    mismatches  = 0;
    sent_items  = 0;
    idle_cycles = 0;
    in_calm     = 1'b0;
    out_calm    = 1'b0;
    first       = 1'b1;
    m_width     = WM_64;
    clear_parse();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    add_row(WM_64, "", -1, 1, 0, 1);
    add_row(WM_64, "0", -1, 1, 0, 0);
    add_row(WM_64, "-9223372036854775808", -1, 1, I64_MIN, 0);
    add_row(WM_64, "9223372036854775807", -1, 1, I64_MAX, 0);
    add_row(WM_64, "+9223372036854775808", -1, 1, 0, 1);
    add_row(WM_64, "-9223372036854775809", -1, 1, 0, 1);
    add_row(WM_64, "99999999999999999999", -1, 1, 0, 1);
    add_row(WM_64, "+", -1, 1, 0, 1);
    add_row(WM_64, "-", -1, 1, 0, 1);
    add_row(WM_64, "12-3", -1, 1, 0, 1);
    add_row(WM_64, "+-5", -1, 1, 0, 1);
    add_row(WM_64, "5\377", -1, 1, 0, 1);
    add_row(WM_64, " 5", -1, 1, 0, 1);
    add_row(WM_64, "000042", -1, 1, 42, 0);
    add_row(WM_64, "+17", 1, 0, 0, 0);
    add_row(WM_64, "-0", -1, 1, 0, 0);
    add_row(WM_8, "127", -1, 1, 127, 0);
    add_row(WM_8, "-128", -1, 1, -128, 0);
    add_row(WM_8, "128", -1, 1, 0, 1);
    add_row(WM_8, "-129", -1, 1, 0, 1);
    add_row(WM_16, "-32768", -1, 1, -32768, 0);
    add_row(WM_16, "32768", -1, 1, 0, 1);
    add_row(WM_16, "+4095", -1, 0, 0, 0);
    add_row(WM_32, "2147483647", -1, 1, 2147483647, 0);
    add_row(WM_32, "-2147483649", -1, 1, 0, 1);
    add_row(WM_32, "-271828", -1, 0, 0, 0);

    foreach (dir_rows[r]) begin
      if (first || dir_rows[r].mode != m_width)
        write_width(dir_rows[r].mode);
      first = 1'b0;
      bytes.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++)
        bytes.push_back(dir_rows[r].text[i]);
      send_string(bytes, dir_rows[r].skip_at, 1'b0, 1'b0,
                  dir_rows[r].typed, dir_rows[r].want);
    end

    n_str = 0;
    while (sent_items < ITEM_TARGET) begin
      if (n_str % 30 == 0)
        write_width(2'($urandom_range(0, 3)));
      else if (n_str % 50 == 25)
        wait_drained();
      make_string();
      tail = str_bytes.size() != 0 && $urandom_range(0, 9) == 0;
      send_string(str_bytes, -1, 1'b1, tail, 1'b0, '0);
      n_str++;
    end

    wait_drained();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
